>>> rtl/core/ksd_pkg.sv
// Shared types, constants and helpers for the keyword substitution decipher.
// Used by ksd_ctrl, ksd_datapath and keyword_substitution_decipher.
package ksd_pkg;

  localparam int ALPHA   = 26;
  localparam int MAX_KEY = 26;
  localparam int LW      = 5;

  typedef logic [LW-1:0] letter_t;

  localparam logic OP_KEY      = 1'b0;
  localparam logic OP_DECIPHER = 1'b1;

  typedef struct packed {
    logic accept_key;
    logic accept_dec;
    logic start_build;
    logic key_step;
    logic fill_step;
    logic finish;
    logic out_pop;
  } ksd_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic key_done;
    logic fill_done;
  } ksd_status_t;

  function automatic letter_t fold_letter(input letter_t v);
    return (v >= LW'(ALPHA)) ? letter_t'(v - LW'(ALPHA)) : v;
  endfunction

endpackage

>>> rtl/core/keyword_substitution_decipher.sv
// Keyword substitution decipher, top level; joins ksd_ctrl and ksd_datapath (ksd_pkg).
// A cipher word's result word is registered in the cycle after acceptance; one word per cycle
// while the result is not stalled and no build runs. A key word marked tlast starts the
// alphabet build: a walk of the stored key letters, then the alphabet fill, input held off.
// Reset (async, active low) clears the key count, the table-ready flag and the output valid bit;
// deciphering before the first build returns key_missing.
module keyword_substitution_decipher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [4:0] letter, [7:5] zero
  input  logic       s_axis_tuser_i,   // [0] operation
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [4:0] plain_letter, [7:5] zero
  output logic       m_axis_tuser_o    // [0] key_missing
);
  import ksd_pkg::*;

  ksd_cmd_t    cmd;
  ksd_status_t status;
  letter_t     plain_letter;

  ksd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_op_i     (s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .in_ready_o  (s_axis_tready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ksd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_letter_i    (s_axis_tdata_i[LW-1:0]),
    .cmd_i          (cmd),
    .status_o       (status),
    .plain_letter_o (plain_letter),
    .key_missing_o  (m_axis_tuser_o)
  );

  assign m_axis_tvalid_o = status.out_valid;
  assign m_axis_tdata_o  = {3'b000, plain_letter};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while result word is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == OP_DECIPHER)) |=> m_axis_tvalid_o)
    else $error("cipher word produced no result word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 8'd0))
    else $error("key_missing result carries a nonzero letter");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fill_step |-> !status.fill_done)
    else $error("fill step issued with a complete alphabet");

endmodule

>>> rtl/core/ksd_ctrl.sv
// Controller for the keyword substitution decipher: input handshake and build sequencing.
// Depends on ksd_pkg; drives ksd_datapath through command and status structs.
module ksd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  input  logic                in_last_i,
  input  logic                out_ready_i,
  output logic                in_ready_o,
  input  ksd_pkg::ksd_status_t status_i,
  output ksd_pkg::ksd_cmd_t    cmd_o
);
  import ksd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_FILL
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_ready_o = (state_q == ST_IDLE) && (!status_i.out_valid || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_pop = status_i.out_valid && out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op_i == OP_DECIPHER) begin
            cmd_o.accept_dec = 1'b1;
          end else begin
            cmd_o.accept_key = 1'b1;
            if (in_last_i) begin
              cmd_o.start_build = 1'b1;
              state_d = ST_KEY;
            end
          end
        end
      end
      ST_KEY: begin
        if (status_i.key_done) begin
          state_d = ST_FILL;
        end else begin
          cmd_o.key_step = 1'b1;
        end
      end
      ST_FILL: begin
        if (status_i.fill_done) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.fill_step = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/ksd_datapath.sv
// Datapath for the keyword substitution decipher: key store, build walk, table, output word.
// Depends on ksd_pkg; commanded by ksd_ctrl.
module ksd_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ksd_pkg::letter_t     in_letter_i,
  input  ksd_pkg::ksd_cmd_t    cmd_i,
  output ksd_pkg::ksd_status_t status_o,
  output ksd_pkg::letter_t     plain_letter_o,
  output logic                 key_missing_o
);
  import ksd_pkg::*;

  letter_t             key_store_q [ALPHA];
  letter_t             table_q     [ALPHA];
  letter_t             key_count_q;
  letter_t             idx_q;
  letter_t             placed_q;
  letter_t             cur_q;
  logic    [ALPHA-1:0] used_q;
  logic                table_ready_q;
  logic                out_valid_q;
  letter_t             out_letter_q;
  logic                out_missing_q;

  letter_t in_c;
  letter_t key_c;
  letter_t next_c;
  letter_t place_c;
  logic    place_en;

  assign in_c     = fold_letter(in_letter_i);
  assign key_c    = key_store_q[idx_q];
  assign next_c   = (cur_q == LW'(ALPHA - 1)) ? '0 : letter_t'(cur_q + 1'b1);
  assign place_c  = cmd_i.key_step ? key_c : next_c;
  assign place_en = (cmd_i.key_step || cmd_i.fill_step) && !used_q[place_c];

  assign status_o.out_valid = out_valid_q;
  assign status_o.key_done  = (idx_q == key_count_q);
  assign status_o.fill_done = (placed_q == LW'(ALPHA));

  assign plain_letter_o = out_letter_q;
  assign key_missing_o  = out_missing_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_key && (key_count_q < LW'(MAX_KEY))) begin
      key_store_q[key_count_q] <= in_c;
    end
    if (place_en) begin
      table_q[place_c] <= placed_q;
    end
    if (cmd_i.accept_dec) begin
      out_letter_q  <= table_ready_q ? table_q[in_c] : '0;
      out_missing_q <= !table_ready_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q   <= '0;
      idx_q         <= '0;
      placed_q      <= '0;
      cur_q         <= '0;
      used_q        <= '0;
      table_ready_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.accept_key && (key_count_q < LW'(MAX_KEY))) begin
        key_count_q <= letter_t'(key_count_q + 1'b1);
      end else if (cmd_i.finish) begin
        key_count_q <= '0;
      end
      if (cmd_i.start_build) begin
        idx_q    <= '0;
        placed_q <= '0;
        used_q   <= '0;
      end else begin
        if (cmd_i.key_step) begin
          idx_q <= letter_t'(idx_q + 1'b1);
        end
        if (cmd_i.fill_step || place_en) begin
          cur_q <= place_c;
        end
        if (place_en) begin
          used_q[place_c] <= 1'b1;
          placed_q        <= letter_t'(placed_q + 1'b1);
        end
      end
      if (cmd_i.finish) begin
        table_ready_q <= 1'b1;
      end
      if (cmd_i.accept_dec) begin
        out_valid_q <= 1'b1;
      end else if (cmd_i.out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> bench/keyword_substitution_decipher_tb.sv
// Testbench for keyword_substitution_decipher: directed and random key and cipher words.
// Predicts each plain letter with its own alphabet builder; depends on ksd_pkg and the RTL.
module keyword_substitution_decipher_tb;
  import ksd_pkg::*;

  typedef struct {
    letter_t plain;
    logic    missing;
  } plain_word_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'h00;  // [4:0] letter, [7:5] zero
  logic       s_axis_tuser_i  = 1'b0;   // [0] operation
  logic       s_axis_tlast_i  = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // [4:0] plain_letter, [7:5] zero
  logic       m_axis_tuser_o;           // [0] key_missing

  letter_t     key_letters[ALPHA];
  int          key_len      = 0;
  letter_t     plain_of[ALPHA];
  logic        table_built  = 1'b0;
  plain_word_t plain_queue[$];

  int   fail_count     = 0;
  int   words_sent     = 0;
  int   src_max_gap    = 6;
  int   sink_max_stall = 6;
  int   sink_wait      = 0;
  logic sink_fire      = 1'b0;

  keyword_substitution_decipher u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 400000);
    $display("keyword_substitution_decipher_tb: errors");
    $finish;
  end

  function automatic letter_t wrap_letter(input letter_t v);
    return (v >= letter_t'(ALPHA)) ? letter_t'(v - letter_t'(ALPHA)) : v;
  endfunction

  function automatic void build_decipher_table();
    logic [ALPHA-1:0] placed_set;
    letter_t          alphabet[ALPHA];
    int               placed;
    letter_t          c;
    placed_set = '0;
    placed     = 0;
    for (int i = 0; i < key_len; i++) begin
      c = key_letters[i];
      if (!placed_set[c]) begin
        placed_set[c]    = 1'b1;
        alphabet[placed] = c;
        placed++;
      end
    end
    while (placed < ALPHA) begin
      c = alphabet[placed - 1];
      do begin
        c = (c == letter_t'(ALPHA - 1)) ? letter_t'(0) : letter_t'(c + 1);
      end while (placed_set[c]);
      placed_set[c]    = 1'b1;
      alphabet[placed] = c;
      placed++;
    end
    for (int i = 0; i < ALPHA; i++) plain_of[alphabet[i]] = letter_t'(i);
    table_built = 1'b1;
    key_len     = 0;
  endfunction

  function automatic void predict_word(input logic op, input letter_t raw, input logic last);
    letter_t     c;
    plain_word_t w;
    c = wrap_letter(raw);
    if (op == OP_KEY) begin
      if (key_len < MAX_KEY && key_len < ALPHA) begin
        key_letters[key_len] = c;
        key_len++;
      end
      if (last) build_decipher_table();
    end else begin
      w.plain   = table_built ? plain_of[c] : letter_t'(0);
      w.missing = !table_built;
      plain_queue.push_back(w);
    end
  endfunction

  function automatic void report_fail(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, what);
  endfunction

  function automatic letter_t rand_letter();
    return ($urandom_range(7, 0) == 0) ? letter_t'($urandom_range(31, 26))
                                       : letter_t'($urandom_range(25, 0));
  endfunction

  // Hold the word until accepted; keep tvalid high when the next word follows at once.
  task automatic send_word(input logic op, input letter_t letter, input logic last);
    int gap;
    gap = $urandom_range(src_max_gap, 0);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, letter};
    s_axis_tuser_i  <= op;
    s_axis_tlast_i  <= last;
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
    predict_word(op, letter, last);
    words_sent++;
  endtask

  always @(negedge clk_i) begin
    plain_word_t w;
    sink_fire = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    if (sink_fire) begin
      if (plain_queue.size() == 0) begin
        report_fail($sformatf("unexpected result word plain=%0d key_missing=%0d",
                              m_axis_tdata_o[4:0], m_axis_tuser_o));
      end else begin
        w = plain_queue.pop_front();
        if (m_axis_tdata_o[4:0] !== w.plain || m_axis_tuser_o !== w.missing)
          report_fail($sformatf("mismatch: plain exp %0d got %0d, key_missing exp %0d got %0d",
                                w.plain, m_axis_tdata_o[4:0], w.missing, m_axis_tuser_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (sink_fire) sink_wait = $urandom_range(sink_max_stall, 0);
    if (sink_wait > 0) begin
      m_axis_tready_i <= 1'b0;
      sink_wait = sink_wait - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic test_missing_key();
    send_word(OP_DECIPHER, 5'd0, 1'b0);
    send_word(OP_DECIPHER, 5'd25, 1'b1);
    send_word(OP_DECIPHER, 5'd26, 1'b0);
    send_word(OP_DECIPHER, 5'd31, 1'b0);
  endtask

  task automatic test_single_letter_key();
    send_word(OP_KEY, 5'd25, 1'b1);
    send_word(OP_DECIPHER, 5'd25, 1'b0);
    send_word(OP_DECIPHER, 5'd0, 1'b0);
    send_word(OP_DECIPHER, 5'd30, 1'b1);
  endtask

  task automatic test_repeated_letters();
    send_word(OP_KEY, 5'd3, 1'b0);
    send_word(OP_KEY, 5'd29, 1'b0);
    send_word(OP_KEY, 5'd31, 1'b0);
    send_word(OP_KEY, 5'd3, 1'b0);
    send_word(OP_KEY, 5'd0, 1'b1);
    send_word(OP_DECIPHER, 5'd0, 1'b0);
    send_word(OP_DECIPHER, 5'd5, 1'b0);
    send_word(OP_DECIPHER, 5'd31, 1'b0);
  endtask

  task automatic test_key_replacement();
    send_word(OP_KEY, 5'd12, 1'b0);
    send_word(OP_DECIPHER, 5'd12, 1'b0);
    send_word(OP_KEY, 5'd12, 1'b1);
    send_word(OP_DECIPHER, 5'd12, 1'b0);
  endtask

  task automatic test_random_traffic();
    int key_words;
    int cipher_words;
    while (words_sent < 1500) begin
      src_max_gap    = ($urandom_range(3, 0) == 0) ? 0 : 6;
      sink_max_stall = ($urandom_range(3, 0) == 0) ? 0 : 6;
      key_words = ($urandom_range(9, 0) == 0) ? $urandom_range(34, 20) : $urandom_range(8, 1);
      if ($urandom_range(7, 0) == 0) key_words = 0;
      for (int i = 0; i < key_words; i++)
        send_word(OP_KEY, rand_letter(),
                  (i == key_words - 1) && ($urandom_range(5, 0) != 0));
      cipher_words = $urandom_range(20, 0);
      for (int i = 0; i < cipher_words; i++)
        send_word(OP_DECIPHER, rand_letter(), 1'($urandom_range(1, 0)));
    end
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tlast_i  <= 1'b0;
    sink_max_stall = 6;
    while (plain_queue.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_missing_key();
    test_single_letter_key();
    test_repeated_letters();
    test_key_replacement();
    test_random_traffic();
    drain_results();
    if (plain_queue.size() != 0)
      report_fail($sformatf("%0d result words never arrived", plain_queue.size()));
    if (fail_count == 0) begin
      $display("keyword_substitution_decipher_tb: clean");
    end else begin
      $display("keyword_substitution_decipher_tb: errors");
    end
    $finish;
  end

endmodule
